FILE: rtl/core/mfcc_pkg.sv
package mfcc_pkg;

  localparam int MAX_CENTRES = 64;
  localparam int ADDR_W      = $clog2(MAX_CENTRES);
  localparam int CNT_W       = $clog2(MAX_CENTRES + 1);
  localparam int DEN_W       = 36;
  localparam int NUM_W       = 48;
  localparam int CFG_W       = 32;
  localparam int DIV_STEPS   = NUM_W;

  // function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CUBE  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_STRENGTH = 2'd0;
  localparam logic [1:0] REG_FALLOFF  = 2'd1;
  localparam logic [1:0] REG_CENTRES  = 2'd2;

  localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

  // corner offsets, bit i belongs to corner i
  localparam logic [7:0] CORNER_DX = 8'h66;
  localparam logic [7:0] CORNER_DY = 8'hF0;
  localparam logic [7:0] CORNER_DZ = 8'hCC;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         slot;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } in_item_t;

  typedef struct packed {
    logic [31:0] potential;
    logic [7:0]  cube_case;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic       vld;
    logic       live;
    logic       last;
    logic       fin;
    logic [2:0] corner;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } div_stage_t;

endpackage

FILE: rtl/core/mfcc_div_cell.sv
module mfcc_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  mfcc_pkg::div_stage_t d_in,
  output mfcc_pkg::div_stage_t d_out
);

  logic [mfcc_pkg::DEN_W:0] trial;
  logic                     ge;
  mfcc_pkg::div_stage_t     stage_nxt;
  mfcc_pkg::div_stage_t     stage_r;

  // one restoring step: bring down a dividend bit, subtract if it fits
  always_comb begin
    trial     = {d_in.rem, d_in.nq[mfcc_pkg::NUM_W-1]};
    ge        = (trial >= {1'b0, d_in.den});
    stage_nxt = d_in;
    if (ge) begin
      stage_nxt.rem = mfcc_pkg::DEN_W'(trial - {1'b0, d_in.den});
    end else begin
      stage_nxt.rem = trial[mfcc_pkg::DEN_W-1:0];
    end
    stage_nxt.nq = {d_in.nq[mfcc_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.tag.vld <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign d_out = stage_r;

endmodule

FILE: rtl/core/mfcc_accum.sv
module mfcc_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfcc_pkg::div_stage_t d_in,
  input  logic [31:0]          strength,
  input  logic                 is_cube,
  output logic                 done,
  output mfcc_pkg::out_item_t  res
);

  logic [31:0] sum_r, sum_nxt;
  logic        sat_r, sat_nxt;
  logic [7:0]  case_r, case_nxt;
  logic        c_clip;
  logic [31:0] contrib;
  logic [32:0] total;
  logic [31:0] sum_new;
  logic        sat_new;
  logic [7:0]  case_new;

  // clip the quotient, add it with saturation, close a corner on its last beat
  always_comb begin
    c_clip   = |d_in.nq[mfcc_pkg::NUM_W-1:32];
    contrib  = 32'd0;
    if (d_in.tag.live) begin
      contrib = c_clip ? mfcc_pkg::SAT_MAX : d_in.nq[31:0];
    end
    total    = {1'b0, sum_r} + {1'b0, contrib};
    sum_new  = total[32] ? mfcc_pkg::SAT_MAX : total[31:0];
    sat_new  = sat_r | (d_in.tag.live & c_clip) | total[32];
    case_new = case_r;
    if (d_in.tag.last) begin
      case_new[d_in.tag.corner] = (sum_new < strength);
    end
    sum_nxt  = sum_r;
    sat_nxt  = sat_r;
    case_nxt = case_r;
    if (d_in.tag.vld) begin
      sum_nxt  = d_in.tag.last ? 32'd0 : sum_new;
      sat_nxt  = d_in.tag.fin ? 1'b0 : sat_new;
      case_nxt = d_in.tag.fin ? 8'd0 : case_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= 32'd0;
      sat_r  <= 1'b0;
      case_r <= 8'd0;
    end else begin
      sum_r  <= sum_nxt;
      sat_r  <= sat_nxt;
      case_r <= case_nxt;
    end
  end

  // result of the item on its final beat
  assign done          = d_in.tag.vld & d_in.tag.fin;
  assign res.potential = is_cube ? 32'd0 : sum_new;
  assign res.cube_case = is_cube ? case_new : 8'd0;
  assign res.saturated = sat_new;

endmodule

FILE: rtl/core/metaball_field_cube_classifier.sv
// Metaball field and marching-cubes classifier. Centres are loaded with
// write beats (func 0); a query beat (func 1) returns the Q16.16 potential
// strength/(r^2+falloff^2) summed over the first centres_in_use centres, and
// a cube beat (func 2) returns the 8-bit case index of the cube of edge
// falloff whose first corner is the given point. One centre enters the
// datapath per cycle and each quotient is formed by a row of 48 divider
// cells, one quotient bit per cell; a query walks the n centres in use once
// and a cube walks them once for each of its 8 corners (a zero count still
// costs one slot per corner, as if n were one). A write or unused-func beat
// returns a zero result through the pending and output registers. One item
// is in work at a time; the next beat is taken while the previous result
// waits at the output.
module metaball_field_cube_classifier (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mfcc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mfcc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [mfcc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [31:0]                   strength_r;
  logic [15:0]                   falloff_r;
  logic [mfcc_pkg::CNT_W-1:0]    ciu_r;

  logic [1:0]                    state_r, state_nxt;
  logic [mfcc_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic [2:0]                    corner_r, corner_nxt;
  mfcc_pkg::in_item_t            pt_r;
  logic                          is_cube_r;

  logic [47:0]                   mem [mfcc_pkg::MAX_CENTRES];
  logic [47:0]                   rd_r;

  mfcc_pkg::out_item_t           pend_r, out_r;
  logic                          pend_vld_r, out_valid_r;

  logic                          accept;
  logic [mfcc_pkg::CNT_W-1:0]    n_eff;
  logic                          empty;
  mfcc_pkg::tag_t                iss_tag;

  mfcc_pkg::tag_t                t1_r, t2_r, t3_r;
  logic signed [17:0]            cx, cy, cz;
  logic signed [18:0]            dx, dy, dz;
  logic [16:0]                   ax, ay, az;
  logic [16:0]                   ax_r, ay_r, az_r;
  logic [33:0]                   sqx_r, sqy_r, sqz_r;
  logic [31:0]                   f2_r;
  mfcc_pkg::div_stage_t          s0_nxt, s0_r;
  mfcc_pkg::div_stage_t          chain [mfcc_pkg::DIV_STEPS+1];

  logic                          acc_done;
  mfcc_pkg::out_item_t           acc_res;

  assign accept   = in_valid & in_ready;
  assign in_ready = (state_r == ST_IDLE) & ~pend_vld_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= 32'd65536;
      falloff_r  <= 16'd256;
      ciu_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mfcc_pkg::REG_STRENGTH: strength_r <= cfg_wdata[31:0];
        mfcc_pkg::REG_FALLOFF:  falloff_r  <= cfg_wdata[15:0];
        mfcc_pkg::REG_CENTRES:  ciu_r      <= cfg_wdata[mfcc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // issue one centre per cycle, corner by corner
  always_comb begin
    n_eff = (ciu_r > mfcc_pkg::CNT_W'(mfcc_pkg::MAX_CENTRES))
          ? mfcc_pkg::CNT_W'(mfcc_pkg::MAX_CENTRES) : ciu_r;
    empty = (n_eff == '0);
    iss_tag.vld    = (state_r == ST_RUN);
    iss_tag.live   = ~empty;
    iss_tag.last   = empty | ({1'b0, idx_r} == (n_eff - mfcc_pkg::CNT_W'(1)));
    iss_tag.corner = corner_r;
    iss_tag.fin    = iss_tag.last & (corner_r == (is_cube_r ? 3'd7 : 3'd0));
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    corner_nxt = corner_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.func == mfcc_pkg::FUNC_QUERY ||
                       in_data.func == mfcc_pkg::FUNC_CUBE)) begin
          state_nxt  = ST_RUN;
          idx_nxt    = '0;
          corner_nxt = 3'd0;
        end
      end
      ST_RUN: begin
        if (iss_tag.last) begin
          idx_nxt    = '0;
          corner_nxt = corner_r + 3'd1;
        end else begin
          idx_nxt = idx_r + mfcc_pkg::ADDR_W'(1);
        end
        if (iss_tag.fin) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (acc_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      corner_r <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_r      <= in_data;
      is_cube_r <= (in_data.func == mfcc_pkg::FUNC_CUBE);
    end
  end

  // centre table
  always_ff @(posedge clk) begin
    if (accept && in_data.func == mfcc_pkg::FUNC_WRITE) begin
      mem[in_data.slot] <= {in_data.px, in_data.py, in_data.pz};
    end
    rd_r <= mem[idx_r];
  end

  // corner point minus centre, magnitude only
  always_comb begin
    cx = 18'(pt_r.px) + (mfcc_pkg::CORNER_DX[t1_r.corner] ? $signed({2'b00, falloff_r}) : 18'sd0);
    cy = 18'(pt_r.py) + (mfcc_pkg::CORNER_DY[t1_r.corner] ? $signed({2'b00, falloff_r}) : 18'sd0);
    cz = 18'(pt_r.pz) + (mfcc_pkg::CORNER_DZ[t1_r.corner] ? $signed({2'b00, falloff_r}) : 18'sd0);
    dx = 19'(cx) - 19'($signed(rd_r[47:32]));
    dy = 19'(cy) - 19'($signed(rd_r[31:16]));
    dz = 19'(cz) - 19'($signed(rd_r[15:0]));
    ax = dx[18] ? 17'(-dx) : dx[16:0];
    ay = dy[18] ? 17'(-dy) : dy[16:0];
    az = dz[18] ? 17'(-dz) : dz[16:0];
  end

  // front pipeline: read, difference, squares, denominator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.vld <= 1'b0;
      t2_r.vld <= 1'b0;
      t3_r.vld <= 1'b0;
    end else begin
      t1_r <= iss_tag;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r  <= ax;
    ay_r  <= ay;
    az_r  <= az;
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
    sqz_r <= az_r * az_r;
    f2_r  <= falloff_r * falloff_r;
  end

  always_comb begin
    s0_nxt.tag = t3_r;
    s0_nxt.den = mfcc_pkg::DEN_W'(sqx_r) + mfcc_pkg::DEN_W'(sqy_r)
               + mfcc_pkg::DEN_W'(sqz_r) + mfcc_pkg::DEN_W'(f2_r);
    s0_nxt.rem = '0;
    s0_nxt.nq  = {strength_r, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.tag.vld <= 1'b0;
    end else begin
      s0_r <= s0_nxt;
    end
  end

  // divider row, one quotient bit per cell
  assign chain[0] = s0_r;

  for (genvar g = 0; g < mfcc_pkg::DIV_STEPS; g++) begin : g_div
    mfcc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  mfcc_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .d_in     (chain[mfcc_pkg::DIV_STEPS]),
    .strength (strength_r),
    .is_cube  (is_cube_r),
    .done     (acc_done),
    .res      (acc_res)
  );

  // pending result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pend_vld_r && (!out_valid_r || out_ready)) begin
        out_r       <= pend_r;
        out_valid_r <= 1'b1;
        pend_vld_r  <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_data.func != mfcc_pkg::FUNC_QUERY &&
          in_data.func != mfcc_pkg::FUNC_CUBE) begin
        pend_r     <= '0;
        pend_vld_r <= 1'b1;
      end else if (acc_done) begin
        pend_r     <= acc_res;
        pend_vld_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> state_r == ST_WAIT) else $error("result beat outside wait");

  a_run_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> !pend_vld_r) else $error("issuing with result pending");

  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.func == mfcc_pkg::FUNC_QUERY ||
                in_data.func == mfcc_pkg::FUNC_CUBE)) |=> state_r == ST_RUN)
    else $error("field beat did not start issue");

endmodule
